@@ rtl/core/efhc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efhc_pkg
// Shared types and constants for the Ethernet frame header classifier.
// ----------------------------------------------------------------------------
package efhc_pkg;

   // byte counter saturates here; must exceed every header offset examined
   localparam int COUNT_LIMIT = 2047;
   localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);

   // capture windows, in bytes
   localparam int LLC_BYTES = 8;
   localparam int NET_BYTES = 28;
   localparam int TRN_BYTES = 14;
   localparam int LLC_IDX_W = $clog2(LLC_BYTES);
   localparam int NET_IDX_W = $clog2(NET_BYTES);
   localparam int TRN_IDX_W = $clog2(TRN_BYTES);

   // ethertypes and protocol codes
   localparam logic [15:0] ETH_VLAN      = 16'h8100;
   localparam logic [15:0] ETH_IPV4      = 16'h0800;
   localparam logic [15:0] ETH_ARP       = 16'h0806;
   localparam logic [15:0] ETH_IPV6      = 16'h86dd;
   localparam logic [15:0] ETH_LEN_CEIL  = 16'd1500;
   localparam logic [7:0]  SAP_STP       = 8'h42;
   localparam logic [7:0]  SAP_SNAP      = 8'haa;
   localparam logic [23:0] OUI_CDP_ORG   = 24'h00000c;
   localparam logic [23:0] OUI_RFC1042   = 24'h000000;
   localparam logic [23:0] OUI_8021H     = 24'h0000f8;
   localparam logic [15:0] PID_CDP       = 16'h2000;
   localparam logic [15:0] PID_PVST      = 16'h010b;
   localparam logic [12:0] FRAG_MASK     = 13'h1fff;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] ARP_OP_REQ    = 16'd1;
   localparam logic [15:0] ARP_OP_ANSWER = 16'd2;
   localparam logic [12:0] VLAN_NONE     = 13'd4096;

   // frame kinds
   localparam logic [3:0] KIND_RUNT      = 4'd0;
   localparam logic [3:0] KIND_VLAN_CUT  = 4'd1;
   localparam logic [3:0] KIND_LLC_SHORT = 4'd2;
   localparam logic [3:0] KIND_STP       = 4'd3;
   localparam logic [3:0] KIND_LLC_OTHER = 4'd4;
   localparam logic [3:0] KIND_CDP       = 4'd5;
   localparam logic [3:0] KIND_SNAP      = 4'd6;
   localparam logic [3:0] KIND_IPV4_UNP  = 4'd7;
   localparam logic [3:0] KIND_ICMP      = 4'd8;
   localparam logic [3:0] KIND_TCP       = 4'd9;
   localparam logic [3:0] KIND_UDP       = 4'd10;
   localparam logic [3:0] KIND_IPV4_OTH  = 4'd11;
   localparam logic [3:0] KIND_ARP       = 4'd12;
   localparam logic [3:0] KIND_ARP_OTH   = 4'd13;
   localparam logic [3:0] KIND_IPV6      = 4'd14;
   localparam logic [3:0] KIND_OTHER     = 4'd15;

   // ARP classes
   localparam logic [15:0] ARP_PROBE    = 16'd0;
   localparam logic [15:0] ARP_ANNOUNCE = 16'd1;
   localparam logic [15:0] ARP_REQUEST  = 16'd2;
   localparam logic [15:0] ARP_REPLY    = 16'd3;
   localparam logic [15:0] ARP_UNKNOWN  = 16'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [3:0]  frame_kind;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [12:0] vlan_tag;
      logic [15:0] type_code;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic        ports_valid;
      logic        info_valid;
      logic [15:0] info_value;
   } rsp_beat_type;

   typedef logic [7:0] byte_type;

   // header fields captured from one frame, handed to the classifier
   typedef struct packed {
      logic [CNT_W-1:0]              cap;
      logic [95:0]                   macs;
      logic [15:0]                   etype0;
      logic [11:0]                   tci;
      logic [15:0]                   inner;
      byte_type [LLC_BYTES-1:0]      llc;
      byte_type [NET_BYTES-1:0]      net;
      byte_type [TRN_BYTES-1:0]      trn;
   } hdr_type;

endpackage

@@ rtl/core/efhc_capture.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efhc_capture
// Counts frame bytes and latches the header bytes of interest at offsets
// derived from what has already arrived (VLAN tag, LLC/SNAP, IP header length).
// ----------------------------------------------------------------------------
module efhc_capture (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  accept,
   input  efhc_pkg::req_beat_type beat,
   output logic                  pend,
   output efhc_pkg::hdr_type     hdr
);
   import efhc_pkg::*;

   logic [CNT_W-1:0] n_ff, n_in, cap_in;
   logic             pend_ff;
   logic [CNT_W-1:0] cap_ff;
   logic [95:0]      macs_ff;
   logic [15:0]      etype0_ff, inner_ff;
   logic [11:0]      tci_ff;
   byte_type [LLC_BYTES-1:0] llc_ff;
   byte_type [NET_BYTES-1:0] net_ff;
   byte_type [TRN_BYTES-1:0] trn_ff;

   logic             vlan;
   logic [15:0]      etype1;
   logic [CNT_W-1:0] off1, l3, l4, rel_llc, rel_net, rel_trn;

   // running offsets of each header layer
   always_comb begin
      vlan    = (etype0_ff == ETH_VLAN);
      etype1  = vlan ? inner_ff : etype0_ff;
      off1    = vlan ? CNT_W'(18) : CNT_W'(14);
      l3      = (etype1 <= ETH_LEN_CEIL) ? off1 + CNT_W'(8) : off1;
      l4      = l3 + CNT_W'({net_ff[0][3:0], 2'b00});
      rel_llc = n_ff - off1;
      rel_net = n_ff - l3;
      rel_trn = n_ff - l4;
      cap_in  = (n_ff < CNT_W'(COUNT_LIMIT)) ? n_ff + CNT_W'(1) : CNT_W'(COUNT_LIMIT);
      n_in    = beat.last_byte ? '0 : cap_in;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (accept) n_ff <= n_in;
         if (advance) pend_ff <= accept & beat.last_byte;
      end
   end

   // header byte capture
   always_ff @(posedge clock) begin
      if (accept) begin
         if (beat.last_byte) cap_ff <= cap_in;
         if (n_ff < CNT_W'(12)) macs_ff <= {macs_ff[87:0], beat.data_byte};
         if (n_ff == CNT_W'(12) || n_ff == CNT_W'(13))
            etype0_ff <= {etype0_ff[7:0], beat.data_byte};
         if (n_ff == CNT_W'(14)) tci_ff[11:8] <= beat.data_byte[3:0];
         if (n_ff == CNT_W'(15)) tci_ff[7:0] <= beat.data_byte;
         if (n_ff == CNT_W'(16) || n_ff == CNT_W'(17))
            inner_ff <= {inner_ff[7:0], beat.data_byte};
         if (n_ff >= off1 && rel_llc < CNT_W'(LLC_BYTES))
            llc_ff[rel_llc[LLC_IDX_W-1:0]] <= beat.data_byte;
         if (n_ff >= l3 && rel_net < CNT_W'(NET_BYTES))
            net_ff[rel_net[NET_IDX_W-1:0]] <= beat.data_byte;
         if (n_ff >= l4 && rel_trn < CNT_W'(TRN_BYTES))
            trn_ff[rel_trn[TRN_IDX_W-1:0]] <= beat.data_byte;
      end
   end

   assign pend        = pend_ff;
   assign hdr.cap     = cap_ff;
   assign hdr.macs    = macs_ff;
   assign hdr.etype0  = etype0_ff;
   assign hdr.tci     = tci_ff;
   assign hdr.inner   = inner_ff;
   assign hdr.llc     = llc_ff;
   assign hdr.net     = net_ff;
   assign hdr.trn     = trn_ff;

endmodule

@@ rtl/core/efhc_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efhc_classify
// Turns the captured header bytes of one frame into its classification.
// ----------------------------------------------------------------------------
module efhc_classify (
   input  efhc_pkg::hdr_type      hdr,
   output efhc_pkg::rsp_beat_type rsp
);
   import efhc_pkg::*;

   logic             fin;
   logic [15:0]      et, pid, tot, ulen, op;
   logic [23:0]      oui;
   logic [7:0]       sap, proto;
   logic [CNT_W-1:0] off, l4;
   logic [5:0]       ihl, doff;
   logic [6:0]       hsum;
   logic [12:0]      frag;
   logic [31:0]      spa, tpa;

   always_comb begin
      rsp          = '0;
      rsp.vlan_tag = VLAN_NONE;
      fin   = 1'b0;
      et    = hdr.etype0;
      off   = CNT_W'(14);
      sap   = hdr.llc[0];
      oui   = {hdr.llc[3], hdr.llc[4], hdr.llc[5]};
      pid   = {hdr.llc[6], hdr.llc[7]};
      ihl   = {hdr.net[0][3:0], 2'b00};
      proto = hdr.net[9];
      frag  = {hdr.net[6][4:0], hdr.net[7]} & FRAG_MASK;
      tot   = {hdr.net[2], hdr.net[3]};
      doff  = {hdr.trn[12][7:4], 2'b00};
      hsum  = {1'b0, ihl} + {1'b0, doff};
      ulen  = {hdr.trn[4], hdr.trn[5]};
      op    = {hdr.net[6], hdr.net[7]};
      spa   = {hdr.net[14], hdr.net[15], hdr.net[16], hdr.net[17]};
      tpa   = {hdr.net[24], hdr.net[25], hdr.net[26], hdr.net[27]};
      l4    = '0;

      if (hdr.cap < CNT_W'(14)) begin
         fin = 1'b1;
      end else begin
         rsp.dest_mac   = hdr.macs[95:48];
         rsp.source_mac = hdr.macs[47:0];
      end

      // 802.1Q tag
      if (!fin && et == ETH_VLAN) begin
         if (hdr.cap < CNT_W'(18)) begin
            rsp.frame_kind = KIND_VLAN_CUT;
            rsp.type_code  = ETH_VLAN;
            fin = 1'b1;
         end else begin
            rsp.vlan_tag = {1'b0, hdr.tci};
            et  = hdr.inner;
            off = CNT_W'(18);
         end
      end

      // 802.3 LLC / SNAP
      if (!fin && et <= ETH_LEN_CEIL) begin
         fin = 1'b1;
         if (hdr.cap < off + CNT_W'(3)) begin
            rsp.frame_kind = KIND_LLC_SHORT;
            rsp.type_code  = et;
         end else if (sap == SAP_STP) begin
            rsp.frame_kind = KIND_STP;
            rsp.type_code  = {8'h00, sap};
         end else if (sap != SAP_SNAP || hdr.cap < off + CNT_W'(8)) begin
            rsp.frame_kind = KIND_LLC_OTHER;
            rsp.type_code  = {8'h00, sap};
         end else if (oui == OUI_CDP_ORG && pid == PID_CDP) begin
            rsp.frame_kind = KIND_CDP;
            rsp.type_code  = pid;
         end else if (oui == OUI_CDP_ORG && pid == PID_PVST) begin
            rsp.frame_kind = KIND_STP;
            rsp.type_code  = {8'h00, sap};
         end else if (oui != OUI_RFC1042 && oui != OUI_8021H) begin
            rsp.frame_kind = KIND_SNAP;
            rsp.type_code  = pid;
         end else begin
            fin = 1'b0;
            et  = pid;
            off = off + CNT_W'(8);
         end
      end

      l4 = off + CNT_W'(ihl);

      if (!fin) begin
         if (et == ETH_IPV4) begin
            // IPv4 and its transport header
            if (hdr.cap < off + CNT_W'(20) || hdr.net[0][7:4] != 4'd4) begin
               rsp.frame_kind = KIND_IPV4_UNP;
               rsp.type_code  = et;
            end else begin
               rsp.source_addr = {hdr.net[12], hdr.net[13], hdr.net[14], hdr.net[15]};
               rsp.dest_addr   = {hdr.net[16], hdr.net[17], hdr.net[18], hdr.net[19]};
               if (proto == PROTO_ICMP) begin
                  rsp.frame_kind = KIND_ICMP;
                  if (frag == '0 && ihl >= 6'd20 && hdr.cap >= l4 + CNT_W'(2)) begin
                     rsp.type_code  = {hdr.trn[0], hdr.trn[1]};
                     rsp.info_valid = 1'b1;
                  end
               end else if (proto != PROTO_TCP && proto != PROTO_UDP) begin
                  rsp.frame_kind = KIND_IPV4_OTH;
                  rsp.type_code  = {8'h00, proto};
               end else begin
                  rsp.frame_kind = (proto == PROTO_TCP) ? KIND_TCP : KIND_UDP;
                  if (proto == PROTO_UDP) rsp.type_code = {8'h00, proto};
                  if (frag == '0 && ihl >= 6'd20 && hdr.cap >= l4 + CNT_W'(4)) begin
                     rsp.source_port = {hdr.trn[0], hdr.trn[1]};
                     rsp.dest_port   = {hdr.trn[2], hdr.trn[3]};
                     rsp.ports_valid = 1'b1;
                     if (proto == PROTO_TCP && hdr.cap >= l4 + CNT_W'(14)) begin
                        rsp.type_code  = {8'h00, hdr.trn[13]};
                        rsp.info_valid = 1'b1;
                        rsp.info_value = (tot > {9'd0, hsum}) ? tot - {9'd0, hsum} : '0;
                     end
                     if (proto == PROTO_UDP && hdr.cap >= l4 + CNT_W'(6)) begin
                        rsp.info_valid = 1'b1;
                        rsp.info_value = (ulen > 16'd8) ? ulen - 16'd8 : '0;
                     end
                  end
               end
            end
         end else if (et == ETH_ARP) begin
            // Ethernet/IPv4 ARP only
            if (!(hdr.cap >= off + CNT_W'(28) && {hdr.net[0], hdr.net[1]} == 16'd1
                  && {hdr.net[2], hdr.net[3]} == ETH_IPV4 && hdr.net[4] == 8'd6
                  && hdr.net[5] == 8'd4)) begin
               rsp.frame_kind = KIND_ARP_OTH;
               rsp.type_code  = et;
            end else begin
               rsp.frame_kind  = KIND_ARP;
               rsp.type_code   = op;
               rsp.source_addr = spa;
               rsp.dest_addr   = tpa;
               rsp.info_valid  = 1'b1;
               if (op == ARP_OP_REQ && spa == '0) rsp.info_value = ARP_PROBE;
               else if (spa == tpa)               rsp.info_value = ARP_ANNOUNCE;
               else if (op == ARP_OP_REQ)         rsp.info_value = ARP_REQUEST;
               else if (op == ARP_OP_ANSWER)      rsp.info_value = ARP_REPLY;
               else                               rsp.info_value = ARP_UNKNOWN;
            end
         end else begin
            rsp.frame_kind = (et == ETH_IPV6) ? KIND_IPV6 : KIND_OTHER;
            rsp.type_code  = et;
         end
      end
   end

endmodule

@@ rtl/core/ethernet_frame_header_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_frame_header_classifier
// Byte-wide frame input, one header classification per frame.
// ----------------------------------------------------------------------------
//   channel  | direction | beat
//   req_     | in        | one frame byte, last_byte marks frame end
//   rsp_     | out       | one classification, per frame
//
// One byte is taken every cycle while req_stall is low; header bytes are latched as they pass.
// After the last byte is taken, the header bytes and pend flag are registered,
// then the classifier logic result is loaded into the rsp_ register.
// Reset clears the byte counter and all valid flags; a frame in flight is lost.
// While a result is held by rsp_stall, req_stall is raised.
// ----------------------------------------------------------------------------
module ethernet_frame_header_classifier (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  efhc_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output efhc_pkg::rsp_beat_type rsp_beat
);
   import efhc_pkg::*;

   logic         advance, accept, pend;
   hdr_type      hdr;
   rsp_beat_type rsp_in, rsp_ff;
   logic         rsp_valid_ff;

   // pipeline moves unless a valid result is held by rsp_stall
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   efhc_capture u_capture (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .accept  (accept),
      .beat    (req_beat),
      .pend    (pend),
      .hdr     (hdr)
   );

   efhc_classify u_classify (
      .hdr (hdr),
      .rsp (rsp_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pend;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pend) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

@@ verif/ethernet_frame_header_classifier_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_frame_header_classifier_test
// Self-checking bench for the frame header classifier. Frames are built
// byte by byte, from directed table rows and then from random well-formed
// or broken headers, and fed with random gaps. A software classifier
// predicts each frame result, and the rsp_ beats are checked against it
// field by field under random back-pressure.
// ----------------------------------------------------------------------------
module ethernet_frame_header_classifier_test;
   import efhc_pkg::*;

   localparam int MAX_FRAME   = 2200;
   localparam int CYCLE_LIMIT = 600000;

   // frame builders
   typedef enum int {F_RAND, F_IPV4, F_ARP, F_LLC, F_SNAP, F_L3} frame_sel_type;

   typedef struct {
      frame_sel_type sel;
      int            sub;
      bit            vlan;
      int            len;
      bit            typed;   // expected result is the fixed runt result
   } frame_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_beat = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_beat;

   byte_type     fb [0:MAX_FRAME-1];
   rsp_beat_type pending_results [$];
   int           errors = 0;
   int           cycles = 0;
   int           rsp_wait = 0;
   bit           idle_on = 1'b1;

   ethernet_frame_header_classifier DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_beat(req_beat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // cycle count and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int g8(int i);
      return fb[i & 127];
   endfunction

   function automatic int g16(int i);
      return (g8(i) << 8) | g8(i + 1);
   endfunction

   function automatic logic [31:0] g32(int i);
      return {16'(g16(i)), 16'(g16(i + 2))};
   endfunction

   // classification of the frame held in fb, captured length cap
   function automatic rsp_beat_type classify_frame(int cap);
      rsp_beat_type r;
      int off, et, sap, oui, pid, ihl, p, frag, l4, doff, tot, ulen, op;
      logic [31:0] spa, tpa;
      r = '0;
      r.vlan_tag = VLAN_NONE;
      if (cap < 14) return r;
      r.dest_mac = {16'(g16(0)), g32(2)};
      r.source_mac = {16'(g16(6)), g32(8)};
      off = 14;
      et = g16(12);
      if (et == ETH_VLAN) begin
         if (cap < off + 4) begin
            r.frame_kind = KIND_VLAN_CUT;
            r.type_code = ETH_VLAN;
            return r;
         end
         r.vlan_tag = 13'(g16(off) & 'hfff);
         et = g16(off + 2);
         off += 4;
      end
      // 802.3 length with LLC / SNAP
      if (et <= ETH_LEN_CEIL) begin
         if (cap < off + 3) begin
            r.frame_kind = KIND_LLC_SHORT;
            r.type_code = 16'(et);
            return r;
         end
         sap = g8(off);
         if (sap == SAP_STP) begin
            r.frame_kind = KIND_STP;
            r.type_code = 16'(sap);
            return r;
         end
         if (sap != SAP_SNAP || cap < off + 8) begin
            r.frame_kind = KIND_LLC_OTHER;
            r.type_code = 16'(sap);
            return r;
         end
         oui = (g8(off + 3) << 16) | g16(off + 4);
         pid = g16(off + 6);
         off += 8;
         if (oui == OUI_CDP_ORG && pid == PID_CDP) begin
            r.frame_kind = KIND_CDP;
            r.type_code = 16'(pid);
            return r;
         end
         if (oui == OUI_CDP_ORG && pid == PID_PVST) begin
            r.frame_kind = KIND_STP;
            r.type_code = 16'(sap);
            return r;
         end
         if (oui != OUI_RFC1042 && oui != OUI_8021H) begin
            r.frame_kind = KIND_SNAP;
            r.type_code = 16'(pid);
            return r;
         end
         et = pid;
      end
      // IPv4
      if (et == ETH_IPV4) begin
         if (cap < off + 20 || (g8(off) >> 4) != 4) begin
            r.frame_kind = KIND_IPV4_UNP;
            r.type_code = 16'(et);
            return r;
         end
         ihl = (g8(off) & 15) * 4;
         p = g8(off + 9);
         frag = g16(off + 6) & FRAG_MASK;
         r.source_addr = g32(off + 12);
         r.dest_addr = g32(off + 16);
         l4 = off + ihl;
         if (p == PROTO_ICMP) begin
            r.frame_kind = KIND_ICMP;
            if (frag == 0 && ihl >= 20 && cap >= l4 + 2) begin
               r.type_code = 16'(g16(l4));
               r.info_valid = 1'b1;
            end
            return r;
         end
         if (p != PROTO_TCP && p != PROTO_UDP) begin
            r.frame_kind = KIND_IPV4_OTH;
            r.type_code = 16'(p);
            return r;
         end
         r.frame_kind = (p == PROTO_TCP) ? KIND_TCP : KIND_UDP;
         if (p == PROTO_UDP) r.type_code = 16'(p);
         if (frag == 0 && ihl >= 20 && cap >= l4 + 4) begin
            r.source_port = 16'(g16(l4));
            r.dest_port = 16'(g16(l4 + 2));
            r.ports_valid = 1'b1;
            if (p == PROTO_TCP && cap >= l4 + 14) begin
               doff = (g8(l4 + 12) >> 4) * 4;
               tot = g16(off + 2);
               r.type_code = 16'(g8(l4 + 13));
               r.info_valid = 1'b1;
               r.info_value = 16'((tot > ihl + doff) ? tot - ihl - doff : 0);
            end
            if (p == PROTO_UDP && cap >= l4 + 6) begin
               ulen = g16(l4 + 4);
               r.info_valid = 1'b1;
               r.info_value = 16'((ulen > 8) ? ulen - 8 : 0);
            end
         end
         return r;
      end
      // ARP over Ethernet / IPv4
      if (et == ETH_ARP) begin
         if (!(cap >= off + 28 && g16(off) == 1 && g16(off + 2) == ETH_IPV4 &&
               g8(off + 4) == 6 && g8(off + 5) == 4)) begin
            r.frame_kind = KIND_ARP_OTH;
            r.type_code = 16'(et);
            return r;
         end
         op = g16(off + 6);
         spa = g32(off + 14);
         tpa = g32(off + 24);
         r.frame_kind = KIND_ARP;
         r.type_code = 16'(op);
         r.source_addr = spa;
         r.dest_addr = tpa;
         r.info_valid = 1'b1;
         if (op == ARP_OP_REQ && spa == 0) r.info_value = ARP_PROBE;
         else if (spa == tpa) r.info_value = ARP_ANNOUNCE;
         else if (op == ARP_OP_REQ) r.info_value = ARP_REQUEST;
         else if (op == ARP_OP_ANSWER) r.info_value = ARP_REPLY;
         else r.info_value = ARP_UNKNOWN;
         return r;
      end
      r.frame_kind = (et == ETH_IPV6) ? KIND_IPV6 : KIND_OTHER;
      r.type_code = 16'(et);
      return r;
   endfunction

   function automatic void put16(int i, int v);
      fb[i] = 8'(v >> 8);
      fb[i + 1] = 8'(v);
   endfunction

   // IPv4 header plus transport; sub picks the protocol, 4 a bad version
   function automatic void write_ipv4(int off, int sub);
      int ihl;
      ihl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 5;
      fb[off] = (sub == 4) ? {4'($urandom), 4'(ihl)} : {4'd4, 4'(ihl)};
      put16(off + 2, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(20, 200));
      if ($urandom_range(0, 7) != 0) put16(off + 6, $urandom & 16'he000);
      case (sub)
         0: fb[off + 9] = PROTO_ICMP;
         1: fb[off + 9] = PROTO_TCP;
         2: fb[off + 9] = PROTO_UDP;
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) fb[off + 4 * ihl + 12] = 8'h50;
      if ($urandom_range(0, 3) == 0) put16(off + 4 * ihl + 4, $urandom_range(0, 16));
   endfunction

   // ARP body; sub 0 probe, 1 announce, 2 request, 3 reply, 4 odd op, 5 bad format
   function automatic void write_arp(int off, int sub);
      put16(off, 1);
      put16(off + 2, ETH_IPV4);
      fb[off + 4] = 8'd6;
      fb[off + 5] = 8'd4;
      put16(off + 6, (sub == 0 || sub == 2) ? ARP_OP_REQ :
                     (sub == 3) ? ARP_OP_ANSWER :
                     (sub == 4) ? $urandom_range(3, 65535) : $urandom_range(1, 2));
      if (sub == 0) for (int k = 14; k < 18; k++) fb[off + k] = '0;
      if (sub == 1) for (int k = 0; k < 4; k++) fb[off + 24 + k] = fb[off + 14 + k];
      if (sub == 5) fb[off + $urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
   endfunction

   // fills fb with one frame header over random bytes; returns the header end
   function automatic int build_frame(frame_sel_type sel, int sub, bit vlan);
      int off;
      for (int k = 0; k < 128; k++) fb[k] = 8'($urandom);
      off = 12;
      if (vlan) begin
         put16(off, ETH_VLAN);
         off += 4;
      end
      case (sel)
         F_IPV4: begin
            put16(off, ETH_IPV4);
            write_ipv4(off + 2, sub);
            return off + 2 + 40;
         end
         F_ARP: begin
            put16(off, ETH_ARP);
            write_arp(off + 2, sub);
            return off + 2 + 28;
         end
         F_LLC: begin
            put16(off, ($urandom_range(0, 2) == 0) ? 1500 : $urandom_range(0, 1500));
            if (sub == 0) fb[off + 2] = SAP_STP;
            else if (sub == 2) fb[off + 2] = SAP_SNAP;
            return off + 10;
         end
         F_SNAP: begin
            put16(off, $urandom_range(0, 1500));
            fb[off + 2] = SAP_SNAP;
            fb[off + 5] = '0;
            fb[off + 6] = '0;
            fb[off + 7] = (sub <= 1) ? 8'h0c : (sub == 3) ? 8'hf8 : (sub == 2) ? 8'h00 : fb[off + 7];
            if (sub == 0) put16(off + 8, PID_CDP);
            if (sub == 1) put16(off + 8, PID_PVST);
            if (sub == 2) begin
               put16(off + 8, ETH_IPV4);
               write_ipv4(off + 10, $urandom_range(0, 3));
            end
            if (sub == 3) begin
               put16(off + 8, ETH_ARP);
               write_arp(off + 10, $urandom_range(0, 4));
            end
            return off + 10 + 40;
         end
         F_L3: begin
            put16(off, (sub == 0) ? ETH_IPV6 : (sub == 1) ? 16'hffff : 16'd1501);
            return off + 2;
         end
         default: return off + $urandom_range(2, 40);
      endcase
   endfunction

   // one byte beat; waits for acceptance, gap drawn beforehand
   task automatic send_byte(byte_type b, bit last);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= '{data_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame(int len, bit typed);
      rsp_beat_type runt;
      runt = '0;
      runt.vlan_tag = VLAN_NONE;
      for (int k = 0; k < len; k++) begin
         if (k >= 128) fb[k] = 8'($urandom);
         send_byte(fb[k], k == len - 1);
      end
      pending_results.push_back(typed ? runt : classify_frame(len < COUNT_LIMIT ? len : COUNT_LIMIT));
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // result side: random stall, field checks
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result beat, actual %h", $time, rsp_beat);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("frame_kind", want.frame_kind, rsp_beat.frame_kind);
            check_field("dest_mac", want.dest_mac, rsp_beat.dest_mac);
            check_field("source_mac", want.source_mac, rsp_beat.source_mac);
            check_field("vlan_tag", want.vlan_tag, rsp_beat.vlan_tag);
            check_field("type_code", want.type_code, rsp_beat.type_code);
            check_field("source_addr", want.source_addr, rsp_beat.source_addr);
            check_field("dest_addr", want.dest_addr, rsp_beat.dest_addr);
            check_field("source_port", want.source_port, rsp_beat.source_port);
            check_field("dest_port", want.dest_port, rsp_beat.dest_port);
            check_field("ports_valid", want.ports_valid, rsp_beat.ports_valid);
            check_field("info_valid", want.info_valid, rsp_beat.info_valid);
            check_field("info_value", want.info_value, rsp_beat.info_value);
         end
         rsp_wait = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // directed frames
   frame_row_type directed_rows [] = '{
      '{F_RAND, 0, 0, 1, 1},    '{F_RAND, 0, 0, 13, 1},   '{F_RAND, 0, 0, 14, 0},
      '{F_IPV4, 1, 1, 15, 0},   '{F_LLC, 1, 0, 16, 0},    '{F_LLC, 0, 0, 20, 0},
      '{F_LLC, 1, 1, 30, 0},    '{F_LLC, 2, 0, 20, 0},    '{F_SNAP, 0, 0, 30, 0},
      '{F_SNAP, 1, 1, 30, 0},   '{F_SNAP, 2, 0, 90, 0},   '{F_SNAP, 3, 0, 90, 0},
      '{F_SNAP, 4, 0, 40, 0},   '{F_IPV4, 4, 0, 60, 0},   '{F_IPV4, 1, 0, 20, 0},
      '{F_IPV4, 0, 0, 70, 0},   '{F_IPV4, 1, 1, 80, 0},   '{F_IPV4, 2, 0, 70, 0},
      '{F_IPV4, 3, 0, 70, 0},   '{F_ARP, 0, 0, 60, 0},    '{F_ARP, 1, 0, 60, 0},
      '{F_ARP, 2, 1, 60, 0},    '{F_ARP, 3, 0, 60, 0},    '{F_ARP, 4, 0, 60, 0},
      '{F_ARP, 5, 0, 60, 0},    '{F_L3, 0, 0, 20, 0},     '{F_L3, 1, 0, 20, 0},
      '{F_L3, 2, 1, 140, 0}
   };

   initial begin
      int hdr_end, len, bytes_sent, frames_sent, r;
      frame_row_type row;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         hdr_end = build_frame(row.sel, row.sub, row.vlan);
         send_frame(row.len, row.typed);
      end

      // hold off until the result side has drained
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      bytes_sent = 0;
      frames_sent = 0;
      while (bytes_sent < 250) begin
         if (frames_sent % 3 == 0) idle_on = $urandom_range(0, 3) != 0;
         r = $urandom_range(0, 15);
         hdr_end = build_frame(r < 4 ? F_IPV4 : r < 7 ? F_ARP : r < 9 ? F_LLC :
                               r < 11 ? F_SNAP : r < 13 ? F_L3 : F_RAND,
                               $urandom_range(0, 5), $urandom_range(0, 3) == 0);
         r = $urandom_range(0, 39);
         if (r == 0) len = $urandom_range(129, 300);
         else if (r < 10) len = $urandom_range(1, hdr_end);
         else len = $urandom_range(hdr_end - 10, hdr_end + 8);
         send_frame(len, 1'b0);
         bytes_sent += len;
         frames_sent++;
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ ethernet_frame_header_classifier.f @@
rtl/core/efhc_pkg.sv
rtl/core/efhc_capture.sv
rtl/core/efhc_classify.sv
rtl/core/ethernet_frame_header_classifier.sv
verif/ethernet_frame_header_classifier_test.sv
